// File: sv/utf8d_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Shared widths, payload types and sequence constants for the UTF-8 decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 21;
  localparam int unsigned CONT_W = 6;   // payload bits of a continuation byte
  localparam int unsigned REM_W  = 2;   // bytes still owed to a sequence

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CP_W-1:0]   cp_t;
  typedef logic [REM_W-1:0]  rem_t;

  // Code point reported for a continuation byte seen where a lead is awaited.
  localparam cp_t BAD_LEAD_CP = cp_t'(1);

  // Bytes owed after each kind of lead byte.
  localparam rem_t REM_NONE  = 2'd0;
  localparam rem_t REM_ONE   = 2'd1;
  localparam rem_t REM_TWO   = 2'd2;
  localparam rem_t REM_THREE = 2'd3;

endpackage : utf8d_pkg

// File: sv/utf8d_if.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder channels
// Valid/ready channels for raw bytes in and decoded code points out.
// ----------------------------------------------------------------------------
interface utf8d_byte_if;
  logic             valid;
  logic             ready;
  utf8d_pkg::byte_t data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface : utf8d_byte_if

interface utf8d_cp_if;
  logic           valid;
  logic           ready;
  utf8d_pkg::cp_t code_point;
  logic           bad_lead;

  modport source (output valid, output code_point, output bad_lead, input ready);
  modport sink   (input valid, input code_point, input bad_lead, output ready);
endinterface : utf8d_cp_if

// File: sv/utf8d_in_stage.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder input register
// Captures one byte per cycle while the decode stage keeps taking them, and hands it to the decode stage.
// ----------------------------------------------------------------------------
module utf8d_in_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  utf8d_pkg::byte_t in_data,
  output logic             s1_valid,
  input  logic             s1_take,
  output utf8d_pkg::byte_t s1_data
);
  import utf8d_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  byte_t data_r;

  // The register can load whenever it is empty or its item leaves this cycle.
  assign in_ready  = !valid_r || s1_take;
  assign valid_nxt = (in_valid && in_ready) || (valid_r && !s1_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

  assign s1_valid = valid_r;
  assign s1_data  = data_r;

endmodule : utf8d_in_stage

// File: sv/utf8d_decode.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder core
// Sequence state, byte decode and the result register.
// ----------------------------------------------------------------------------
module utf8d_decode (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             s1_valid,
  output logic             s1_take,
  input  utf8d_pkg::byte_t s1_data,
  output logic             out_valid,
  input  logic             out_ready,
  output utf8d_pkg::cp_t   out_code_point,
  output logic             out_bad_lead
);
  import utf8d_pkg::*;

  rem_t rem_r;
  rem_t rem_nxt;
  cp_t  partial_r;
  cp_t  partial_nxt;
  logic out_valid_r;
  logic out_valid_nxt;
  cp_t  code_r;
  cp_t  code_nxt;
  logic bad_r;
  logic bad_nxt;
  logic emit;
  cp_t  cont_bits;

  // A byte is consumed when the result register is free or drains this cycle.
  assign s1_take = s1_valid && (!out_valid_r || out_ready);

  always_comb begin
    cont_bits   = cp_t'(s1_data[CONT_W-1:0]);
    rem_nxt     = rem_r;
    partial_nxt = partial_r;
    emit        = 1'b0;
    code_nxt    = code_r;
    bad_nxt     = 1'b0;
    if (rem_r != REM_NONE) begin
      case (rem_r)
        REM_THREE: partial_nxt = partial_r | (cont_bits << (2 * CONT_W));
        REM_TWO:   partial_nxt = partial_r | (cont_bits << CONT_W);
        default:   partial_nxt = partial_r | cont_bits;
      endcase
      rem_nxt = rem_r - REM_ONE;
      if (rem_r == REM_ONE) begin
        emit     = 1'b1;
        code_nxt = partial_nxt;
      end
    end else begin
      case (s1_data) inside
        8'b0???_????: begin
          emit     = 1'b1;
          code_nxt = cp_t'(s1_data);
        end
        8'b1111_????: begin
          // Only the low three lead bits are kept, so 0xF8..0xFF act as 4-byte leads.
          partial_nxt = {s1_data[2:0], 18'd0};
          rem_nxt     = REM_THREE;
        end
        8'b1110_????: begin
          partial_nxt = {5'd0, s1_data[3:0], 12'd0};
          rem_nxt     = REM_TWO;
        end
        8'b110?_????: begin
          partial_nxt = {10'd0, s1_data[4:0], 6'd0};
          rem_nxt     = REM_ONE;
        end
        default: begin
          // Stray continuation byte: flag it and leave the state alone.
          emit     = 1'b1;
          code_nxt = BAD_LEAD_CP;
          bad_nxt  = 1'b1;
        end
      endcase
    end
  end

  assign out_valid_nxt = (s1_take && emit) || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r       <= REM_NONE;
      partial_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (s1_take) begin
        rem_r     <= rem_nxt;
        partial_r <= partial_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && emit) begin
      code_r <= code_nxt;
      bad_r  <= bad_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_code_point = code_r;
  assign out_bad_lead   = bad_r;

endmodule : utf8d_decode

// File: sv/utf8_code_point_decoder.sv
// ----------------------------------------------------------------------------
// UTF-8 code point decoder
// Decodes a UTF-8 byte stream into 21-bit code points, one byte per item.
// ----------------------------------------------------------------------------
// The decoder takes one byte per cycle while its output is not stalled and
// produces a code point after the last byte of each sequence (ASCII bytes
// give one at once); a continuation byte where a lead is expected gives code
// point 1 with bad_lead set. Each byte passes through an input register and
// the decode logic into a result register, so out valid rises once the byte
// that completes a code point has moved through both registers. The sustained
// rate is one byte per cycle, set by the single decode stage and its sequence
// state registers, while the output is taken. Continuation bytes inside a
// sequence are not checked, and any 1111xxxx lead starts a four-byte sequence.
module utf8_code_point_decoder (
  input logic           clk,
  input logic           rst_n,
  utf8d_byte_if.sink    in_byte,
  utf8d_cp_if.source    out_cp
);
  import utf8d_pkg::*;

  logic  s1_valid;
  logic  s1_take;
  byte_t s1_data;

  utf8d_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_byte.valid),
    .in_ready (in_byte.ready),
    .in_data  (in_byte.data_byte),
    .s1_valid (s1_valid),
    .s1_take  (s1_take),
    .s1_data  (s1_data)
  );

  utf8d_decode u_decode (
    .clk            (clk),
    .rst_n          (rst_n),
    .s1_valid       (s1_valid),
    .s1_take        (s1_take),
    .s1_data        (s1_data),
    .out_valid      (out_cp.valid),
    .out_ready      (out_cp.ready),
    .out_code_point (out_cp.code_point),
    .out_bad_lead   (out_cp.bad_lead)
  );

endmodule : utf8_code_point_decoder

// File: test/utf8_code_point_decoder_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UTF-8 code point decoder testbench
// Drives raw bytes into the decoder with random gaps on both channels, tracks
// the sequence state alongside the block to predict each code point, and
// checks every returned code point and bad-lead flag in order.
// ----------------------------------------------------------------------------
module utf8_code_point_decoder_test;
  import utf8d_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned RANDOM_BYTES = 1500;
  localparam int unsigned MAX_REPORTS = 10;

  // Top bits that mark each kind of byte.
  localparam logic [1:0] CONT_TAG  = 2'b10;
  localparam logic [2:0] LEAD2_TAG = 3'b110;
  localparam logic [3:0] LEAD3_TAG = 4'b1110;
  localparam logic [3:0] LEAD4_TAG = 4'b1111;

  typedef struct packed {
    cp_t  code_point;
    logic bad_lead;
  } decoded_t;

  class code_point_scoreboard;
    rem_t        owed;
    cp_t         gathered;
    decoded_t    due_cps[$];
    int unsigned failures;
    int unsigned reported;

    function new();
      owed     = REM_NONE;
      gathered = '0;
      failures = 0;
      reported = 0;
    endfunction

    function int unsigned pending();
      return due_cps.size();
    endfunction

    // Advance the sequence state by one accepted byte and queue any code point.
    function void take_byte(byte_t b);
      int shift;
      if (owed != REM_NONE) begin
        shift    = (int'(owed) - 1) * CONT_W;
        gathered = gathered | (cp_t'(b[CONT_W-1:0]) << shift);
        owed     = owed - REM_ONE;
        if (owed == REM_NONE) due_cps.push_back('{gathered, 1'b0});
      end else if (!b[BYTE_W-1]) begin
        due_cps.push_back('{cp_t'(b), 1'b0});
      end else if (b[7:4] == LEAD4_TAG) begin
        gathered = cp_t'(b[2:0]) << 18;
        owed     = REM_THREE;
      end else if (b[7:4] == LEAD3_TAG) begin
        gathered = cp_t'(b[3:0]) << 12;
        owed     = REM_TWO;
      end else if (b[7:5] == LEAD2_TAG) begin
        gathered = cp_t'(b[4:0]) << 6;
        owed     = REM_ONE;
      end else begin
        due_cps.push_back('{BAD_LEAD_CP, 1'b1});
      end
    endfunction

    function void check_result(cp_t cp, logic bad);
      decoded_t want;
      if (due_cps.size() == 0) begin
        failures++;
        if (reported < MAX_REPORTS) begin
          reported++;
          $display("%0t: unexpected code point %h bad_lead %b", $realtime, cp, bad);
        end
        return;
      end
      want = due_cps.pop_front();
      if (cp !== want.code_point || bad !== want.bad_lead) begin
        failures++;
        if (reported < MAX_REPORTS) begin
          reported++;
          $display("%0t: code point %h bad_lead %b, expected %h bad_lead %b",
                   $realtime, cp, bad, want.code_point, want.bad_lead);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int unsigned cycles;
  int unsigned stall_left;
  bit in_idle_on;
  bit out_idle_on;
  code_point_scoreboard sb;

  utf8d_byte_if byte_ch();
  utf8d_cp_if   cp_ch();

  utf8_code_point_decoder dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_byte (byte_ch),
    .out_cp  (cp_ch)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic byte_t cont_byte();
    // Now and then a byte that is not a continuation sits inside a sequence.
    if ($urandom_range(0, 9) == 0) return byte_t'($urandom_range(0, 255));
    return {CONT_TAG, 6'($urandom_range(0, 63))};
  endfunction

  // Called at a falling edge; returns at a falling edge after the item is taken.
  task automatic send_byte(input byte_t b);
    int unsigned gap;
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    do @(posedge clk); while (!byte_ch.ready);
    sb.take_byte(b);
    @(negedge clk);
    gap = in_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      byte_ch.valid     <= 1'b0;
      byte_ch.data_byte <= byte_t'($urandom_range(0, 255));
      repeat (gap) @(negedge clk);
    end
  endtask

  // Always moves on by at least one falling edge, so the caller's idle
  // assignment settles before the next item is driven.
  task automatic drain_results();
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      cp_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      cp_ch.ready <= 1'b0;
      stall_left--;
    end else if (out_idle_on && $urandom_range(0, 99) < 25) begin
      cp_ch.ready <= 1'b0;
      stall_left = pick_gap();
    end else begin
      cp_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && cp_ch.valid && cp_ch.ready)
      sb.check_result(cp_ch.code_point, cp_ch.bad_lead);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("utf8_code_point_decoder verification failed");
      $finish;
    end
  end

  initial begin
    byte_t directed_bytes[$];
    int unsigned sent;
    int unsigned kind;
    int unsigned drained_once;

    sb = new();
    cycles = 0;
    stall_left = 0;
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
    rst_n = 1'b0;
    byte_ch.valid = 1'b0;
    byte_ch.data_byte = '0;
    cp_ch.ready = 1'b0;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ASCII extremes, stray continuations, shortest and longest forms of each
    // sequence length, a 0xF8..0xFF lead, and a plain byte inside a sequence.
    directed_bytes = {8'h00, 8'h7F, 8'h80, 8'hBF,
                      8'hC0, 8'h80, 8'hDF, 8'hBF,
                      8'hE0, 8'h80, 8'h80, 8'hEF, 8'hBF, 8'hBF,
                      8'hF0, 8'h90, 8'h80, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                      8'hC2, 8'h41};
    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

    // Hold the sender off until every code point so far has come back.
    byte_ch.valid <= 1'b0;
    drain_results();

    sent = 0;
    drained_once = 0;
    while (sent < RANDOM_BYTES) begin
      if (sent % 100 < 5) begin
        in_idle_on  = $urandom_range(0, 3) != 0;
        out_idle_on = $urandom_range(0, 3) != 0;
      end
      if (!drained_once && sent >= RANDOM_BYTES / 2) begin
        drained_once = 1;
        byte_ch.valid <= 1'b0;
        drain_results();
      end
      kind = $urandom_range(0, 99);
      if (kind < 25) begin
        send_byte({1'b0, 7'($urandom_range(0, 127))});
        sent += 1;
      end else if (kind < 45) begin
        send_byte({LEAD2_TAG, 5'($urandom_range(0, 31))});
        send_byte(cont_byte());
        sent += 2;
      end else if (kind < 62) begin
        send_byte({LEAD3_TAG, 4'($urandom_range(0, 15))});
        repeat (2) send_byte(cont_byte());
        sent += 3;
      end else if (kind < 80) begin
        send_byte({LEAD4_TAG, 4'($urandom_range(0, 15))});
        repeat (3) send_byte(cont_byte());
        sent += 4;
      end else if (kind < 90) begin
        send_byte({CONT_TAG, 6'($urandom_range(0, 63))});
        sent += 1;
      end else begin
        // Raw noise; may cut a sequence short or start one that is left open.
        send_byte(byte_t'($urandom_range(0, 255)));
        sent += 1;
      end
    end

    byte_ch.valid <= 1'b0;
    drain_results();
    repeat (8) @(posedge clk);

    if (sb.pending() != 0)
      $display("%0d code points never arrived", sb.pending());
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("utf8_code_point_decoder verification clean");
    end else begin
      $display("utf8_code_point_decoder verification failed");
    end
    $finish;
  end

endmodule : utf8_code_point_decoder_test
